FILE: hw/rtl/tet_pkg.sv
// Shared types and constants of the timed event table.
package tet_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;
	localparam int MAX_RESULTS     = 16;
	localparam int ID_W            = 8;
	localparam int IN_TIME_W       = 32;
	localparam int REQ_W           = 3;
	localparam int STATUS_W        = 4;
	localparam int COUNT_W         = 5;

	typedef enum logic [REQ_W-1:0] {
		REQ_ENQUEUE = 3'd0,
		REQ_UPDATE  = 3'd1,
		REQ_REMOVE  = 3'd2,
		REQ_TICK    = 3'd3,
		REQ_CLEAR   = 3'd4
	} req_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_ADDED     = 4'd0,
		ST_REFRESHED = 4'd1,
		ST_UPDATED   = 4'd2,
		ST_NOT_FOUND = 4'd3,
		ST_REMOVED   = 4'd4,
		ST_FULL      = 4'd5,
		ST_DELIVERED = 4'd6,
		ST_NONE_DUE  = 4'd7,
		ST_CLEARED   = 4'd8
	} status_e;

	// Command broadcast from the controller to every cell.
	typedef enum logic [2:0] {
		OP_NONE      = 3'd0,
		OP_EVAL      = 3'd1,
		OP_ADD       = 3'd2,
		OP_TOUCH     = 3'd3,
		OP_SET_DELAY = 3'd4,
		OP_DROP      = 3'd5,
		OP_CLEAR     = 3'd6,
		OP_DELIVER   = 3'd7
	} cell_op_e;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EVAL = 2'd1,
		S_EXEC = 2'd2
	} ctrl_state_e;

	// Information one cell hands to the next one in the row.
	typedef struct packed {
		logic            match_seen;
		logic            free_seen;
		logic            due_seen;
		logic            more_due;
		logic [ID_W-1:0] id;
	} chain_t;

endpackage

FILE: hw/rtl/timed_event_table.sv
// Top level of the timed event table: sequencer plus a row of slot cells.
//
// The table keeps up to TableDepth pending events, each an id, a start time
// and a delay. Requests arrive on the slave stream (s_t*): tuser carries the
// request kind (enqueue, update delay, remove, tick, clear) and tdata the id,
// delay and current time. Each request yields one result transaction on the
// master stream (m_t*), except a tick, which yields one transaction per
// delivered event in ascending slot order (at most 16) or a single one when
// none is due, and unknown kinds, which yield none. tlast marks the final
// result of a request. A request is taken in the idle state, the cells
// compare id and expiry in the evaluate state that follows, and the first
// result is loaded into the output register in the execute state; the row
// of cells evaluates all slots at once and the sequencer then walks the due
// slots one per cycle while the output register is free to take a result.
// Reset empties the table and drops any waiting result. While the receiver
// stalls, the result stays in the output register and the sequencer waits;
// a new request is taken only once the previous one has issued its last
// result, though that result may still be waiting in the output register.
module timed_event_table
	import tet_pkg::*;
#(
	parameter int TableDepth = TABLE_DEPTH_DEF,
	parameter int TimeBits   = TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// tuser: req_type[2:0]
	input  logic [REQ_W-1:0]    s_tuser,
	// tdata: event_id[7:0], delay[39:8], current_time[71:40]
	input  logic [71:0]         s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// tuser: status[3:0]
	output logic [STATUS_W-1:0] m_tuser,
	// tdata: event_id_res[7:0], pending_count[12:8], zero fill[15:13]
	output logic [15:0]         m_tdata,
	output logic                m_tlast
);

	cell_op_e            op;
	logic [ID_W-1:0]     req_id;
	logic [TimeBits-1:0] req_delay;
	logic [TimeBits-1:0] req_now;
	chain_t              link [TableDepth+1];

	// The chain starts empty: nothing seen before the lowest slot.
	assign link[0] = '0;

	tet_ctrl #(
		.TableDepth (TableDepth),
		.TimeBits   (TimeBits)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tuser   (m_tuser),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.op        (op),
		.req_id    (req_id),
		.req_delay (req_delay),
		.req_now   (req_now),
		.chain_end (link[TableDepth])
	);

	// Slot 0 sits at the head of the chain, so it wins every priority pick.
	for (genvar i = 0; i < TableDepth; i++) begin : g_cell
		tet_cell #(
			.TimeBits (TimeBits)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.op        (op),
			.req_id    (req_id),
			.req_delay (req_delay),
			.req_now   (req_now),
			.chain_in  (link[i]),
			.chain_out (link[i+1])
		);
	end

endmodule

FILE: hw/rtl/tet_cell.sv
// One slot of the event table with its match, free and expiry logic.
module tet_cell
	import tet_pkg::*;
#(
	parameter int TimeBits = TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_op_e            op,
	input  logic [ID_W-1:0]     req_id,
	input  logic [TimeBits-1:0] req_delay,
	input  logic [TimeBits-1:0] req_now,
	input  chain_t              chain_in,
	output chain_t              chain_out
);

	logic                valid_q;
	logic                match_q;
	logic                due_q;
	logic [ID_W-1:0]     id_q;
	logic [TimeBits-1:0] start_q;
	logic [TimeBits-1:0] delay_q;

	logic                free;
	logic                first_free;
	logic                first_due;
	logic                due_now;
	logic [TimeBits:0]   expiry;

	// The expiry sum is one bit wider than a time stamp, so it never wraps.
	assign expiry     = {1'b0, start_q} + {1'b0, delay_q};
	assign due_now    = valid_q && (expiry < {1'b0, req_now});
	assign free       = !valid_q;
	assign first_free = free && !chain_in.free_seen;
	assign first_due  = due_q && !chain_in.due_seen;

	always_comb begin
		chain_out.match_seen = chain_in.match_seen | match_q;
		chain_out.free_seen  = chain_in.free_seen | free;
		chain_out.due_seen   = chain_in.due_seen | due_q;
		chain_out.more_due   = chain_in.more_due | (due_q & chain_in.due_seen);
		chain_out.id         = chain_in.id | (first_due ? id_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
			due_q   <= 1'b0;
		end else begin
			unique case (op)
				OP_EVAL: begin
					match_q <= valid_q && (id_q == req_id);
					due_q   <= due_now;
				end
				OP_ADD: begin
					if (first_free) valid_q <= 1'b1;
				end
				OP_DROP: begin
					if (match_q) valid_q <= 1'b0;
					match_q <= 1'b0;
				end
				OP_CLEAR: begin
					valid_q <= 1'b0;
					match_q <= 1'b0;
					due_q   <= 1'b0;
				end
				OP_DELIVER: begin
					if (first_due) begin
						valid_q <= 1'b0;
						due_q   <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_ADD: begin
				if (first_free) begin
					id_q    <= req_id;
					start_q <= req_now;
					delay_q <= req_delay;
				end
			end
			OP_TOUCH: begin
				if (match_q) begin
					start_q <= req_now;
					delay_q <= req_delay;
				end
			end
			OP_SET_DELAY: begin
				if (match_q) delay_q <= req_delay;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/tet_ctrl.sv
// Request sequencer, pending counter and output register of the event table.
module tet_ctrl
	import tet_pkg::*;
#(
	parameter int TableDepth = TABLE_DEPTH_DEF,
	parameter int TimeBits   = TIME_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [REQ_W-1:0]     s_tuser,
	input  logic [71:0]          s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [STATUS_W-1:0]  m_tuser,
	output logic [15:0]          m_tdata,
	output logic                 m_tlast,
	output cell_op_e             op,
	output logic [ID_W-1:0]      req_id,
	output logic [TimeBits-1:0]  req_delay,
	output logic [TimeBits-1:0]  req_now,
	input  chain_t               chain_end
);

	localparam int CntW = $clog2(TableDepth + 1);
	localparam int KW   = $clog2(MAX_RESULTS);
	localparam logic [KW-1:0] KLast = KW'(MAX_RESULTS - 1);

	ctrl_state_e          state_q, state_d;
	req_e                 req_q;
	logic [ID_W-1:0]      req_id_q;
	logic [TimeBits-1:0]  req_delay_q;
	logic [TimeBits-1:0]  req_now_q;
	logic [CntW-1:0]      count_q, count_d;
	logic [KW-1:0]        k_q, k_d;

	logic                 m_tvalid_q;
	status_e              m_status_q;
	logic [ID_W-1:0]      m_id_q;
	logic [COUNT_W-1:0]   m_count_q;
	logic                 m_last_q;

	logic                 out_free;
	logic                 emit;
	status_e              e_status;
	logic [ID_W-1:0]      e_id;
	logic                 e_last;
	logic [CntW+COUNT_W-1:0] count_ext;
	logic [TimeBits+IN_TIME_W-1:0] delay_ext;
	logic [TimeBits+IN_TIME_W-1:0] now_ext;

	assign s_tready  = (state_q == S_IDLE);
	assign out_free  = !m_tvalid_q || m_tready;
	assign delay_ext = {{TimeBits{1'b0}}, s_tdata[39:8]};
	assign now_ext   = {{TimeBits{1'b0}}, s_tdata[71:40]};
	assign count_ext = {{COUNT_W{1'b0}}, count_d};

	assign req_id    = req_id_q;
	assign req_delay = req_delay_q;
	assign req_now   = req_now_q;

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_status_q;
	assign m_tdata  = {3'b000, m_count_q, m_id_q};
	assign m_tlast  = m_last_q;

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		emit     = 1'b0;
		e_status = ST_ADDED;
		e_id     = req_id_q;
		e_last   = 1'b1;
		count_d  = count_q;
		k_d      = k_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_EVAL;
			end
			S_EVAL: begin
				op      = OP_EVAL;
				k_d     = '0;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) begin
					state_d = S_IDLE;
					emit    = 1'b1;
					unique case (req_q)
						REQ_ENQUEUE: begin
							if (chain_end.match_seen) begin
								op       = OP_TOUCH;
								e_status = ST_REFRESHED;
							end else if (chain_end.free_seen) begin
								op       = OP_ADD;
								count_d  = count_q + 1'b1;
								e_status = ST_ADDED;
							end else begin
								e_status = ST_FULL;
							end
						end
						REQ_UPDATE: begin
							if (chain_end.match_seen) begin
								op       = OP_SET_DELAY;
								e_status = ST_UPDATED;
							end else begin
								e_status = ST_NOT_FOUND;
							end
						end
						REQ_REMOVE: begin
							if (chain_end.match_seen) begin
								op       = OP_DROP;
								count_d  = count_q - 1'b1;
								e_status = ST_REMOVED;
							end else begin
								e_status = ST_NOT_FOUND;
							end
						end
						REQ_TICK: begin
							if (chain_end.due_seen) begin
								op       = OP_DELIVER;
								count_d  = count_q - 1'b1;
								e_status = ST_DELIVERED;
								e_id     = chain_end.id;
								e_last   = !chain_end.more_due || (k_q == KLast);
								if (!e_last) begin
									state_d = S_EXEC;
									k_d     = k_q + 1'b1;
								end
							end else begin
								e_status = ST_NONE_DUE;
								e_id     = '0;
							end
						end
						REQ_CLEAR: begin
							op       = OP_CLEAR;
							count_d  = '0;
							e_status = ST_CLEARED;
							e_id     = '0;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			k_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			k_q     <= k_d;
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_q       <= req_e'(s_tuser);
			req_id_q    <= s_tdata[7:0];
			req_delay_q <= delay_ext[TimeBits-1:0];
			req_now_q   <= now_ext[TimeBits-1:0];
		end
		if (emit) begin
			m_status_q <= e_status;
			m_id_q     <= e_id;
			m_count_q  <= count_ext[COUNT_W-1:0];
			m_last_q   <= e_last;
		end
	end

endmodule
